/* rtl/pdf_pkg.sv */
// Shared types and constants of the packet deframer with CRC-16 check and address filter.
package pdf_pkg;

	// CRC-16 with polynomial 0x1021, preset to all ones, fed MSB first.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// Frame layout: the payload starts at byte 6, a checked frame has at least nine bytes.
	localparam logic [8:0] MIN_FRAME      = 9'd9;
	localparam logic [8:0] FOLD_START     = 9'd4;
	localparam logic [8:0] PAYLOAD_OFFSET = 9'd6;
	localparam logic [5:0] MAX_PAYLOAD    = 6'd55;

	// Register reset values.
	localparam logic [7:0]  RST_OWN_ADDRESS       = 8'd0;
	localparam logic        RST_RECEIVE_ALL       = 1'b0;
	localparam logic [7:0]  RST_BROADCAST_ADDRESS = 8'd255;
	localparam logic [7:0]  RST_START_BYTE        = 8'd2;
	localparam logic [7:0]  RST_END_BYTE          = 8'd3;
	localparam logic [15:0] RST_TIMEOUT_TICKS     = 16'd10;

	typedef enum logic [2:0] {
		REG_OWN_ADDRESS       = 3'd0,
		REG_RECEIVE_ALL       = 3'd1,
		REG_BROADCAST_ADDRESS = 3'd2,
		REG_START_BYTE        = 3'd3,
		REG_END_BYTE          = 3'd4,
		REG_TIMEOUT_TICKS     = 3'd5
	} reg_index_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		RK_HEADER        = 2'd0,
		RK_PAYLOAD       = 2'd1,
		RK_NOT_ADDRESSED = 2'd2,
		RK_CRC_ERROR     = 2'd3
	} result_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0]   from_address;
		logic [7:0]   to_address;
		logic [5:0]   payload_length;
		logic [7:0]   data_byte;
		logic         last;
	} result_t;

	typedef struct packed {
		logic [7:0]  own_address;
		logic        receive_all;
		logic [7:0]  broadcast_address;
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// One checked frame, handed from the front to the back.
	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   from_address;
		logic [7:0]   to_address;
		logic [5:0]   len;
	} cmd_t;

endpackage

/* rtl/pdf_store.sv */
// Frame store: one write port, one read port with registered read data.
module pdf_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/pdf_cmd_queue.sv */
// Two-entry queue of checked-frame commands between the front and the back.
module pdf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pdf_pkg::cmd_t push_cmd,
	input  logic          pop,
	output pdf_pkg::cmd_t pop_cmd,
	output logic          full,
	output logic          empty
);

	pdf_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign pop_cmd = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/pdf_front.sv */
// Front end: accepts bytes and ticks, keeps the frame state, folds the CRC and checks frames.
module pdf_front #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pdf_pkg::cfg_t            cfg,
	input  logic                     item_valid,
	input  pdf_pkg::item_t           item,
	output logic                     item_stall,
	output logic                     st_wr_en,
	output logic [$clog2(DEPTH)-1:0] st_wr_addr,
	output logic [7:0]               st_wr_data,
	input  logic                     q_full,
	output logic                     q_push,
	output pdf_pkg::cmd_t            q_cmd,
	input  logic                     back_pending
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		F_IDLE,
		F_CRC,
		F_CHECK
	} f_state_t;

	f_state_t       f_state_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  lock_end_q;
	logic [15:0]    idle_q;
	logic [15:0]    crc_q;
	logic [2:0]     bit_q;
	logic [7:0]     h0_q;
	logic [7:0]     h1_q;
	logic [7:0]     h2_q;
	logic [7:0]     first_q;
	logic [7:0]     to_q;
	logic [7:0]     from_q;

	logic           accept;
	logic           is_byte;
	logic           has_room;
	logic           store_byte;
	logic           write_locked;
	logic [8:0]     fill_ext;
	logic [8:0]     len_full;
	logic [5:0]     len;
	logic [15:0]    idle_inc;
	logic [15:0]    crc_shift;
	logic [15:0]    crc_step;
	logic           check_cond;
	logic           crc_ok;
	logic           addr_ok;

	// Item handshake. Bytes wait while a pending frame may still read the part
	// of the store that they would overwrite.
	assign is_byte      = item.kind == pdf_pkg::KIND_BYTE;
	assign has_room     = fill_q < CW'(DEPTH);
	assign write_locked = back_pending && (fill_q < lock_end_q);
	assign item_stall   = (f_state_q != F_IDLE) || (is_byte && write_locked);
	assign accept       = item_valid && !item_stall;
	assign store_byte   = accept && is_byte && has_room;

	assign st_wr_en   = store_byte;
	assign st_wr_addr = fill_q[AW-1:0];
	assign st_wr_data = item.rx_byte;

	// Saturating idle tick count.
	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

	// One bit of the MSB-first CRC division per cycle.
	assign crc_shift = {crc_q[14:0], 1'b0};
	assign crc_step  = ((crc_q & pdf_pkg::CRC_MSB) != 16'd0) ?
		(crc_shift ^ pdf_pkg::CRC_POLY) : crc_shift;

	// Frame check. The byte just stored sits in h0, the CRC bytes in h2 and h1.
	assign fill_ext   = 9'(fill_q);
	assign check_cond = (fill_ext >= pdf_pkg::MIN_FRAME) && (first_q == cfg.start_byte) &&
		(h0_q == cfg.end_byte);
	assign crc_ok     = (h2_q == crc_q[15:8]) && (h1_q == crc_q[7:0]);
	assign addr_ok    = (to_q == cfg.own_address) || (to_q == cfg.broadcast_address) ||
		cfg.receive_all;
	assign len_full   = fill_ext - pdf_pkg::MIN_FRAME;
	assign len        = (len_full > 9'(pdf_pkg::MAX_PAYLOAD)) ? pdf_pkg::MAX_PAYLOAD :
		len_full[5:0];

	// Command for the back end.
	always_comb begin
		q_cmd.from_address = from_q;
		q_cmd.to_address   = to_q;
		if (!crc_ok) begin
			q_cmd.kind = pdf_pkg::RK_CRC_ERROR;
			q_cmd.len  = 6'd0;
		end else if (!addr_ok) begin
			q_cmd.kind = pdf_pkg::RK_NOT_ADDRESSED;
			q_cmd.len  = 6'd0;
		end else begin
			q_cmd.kind = pdf_pkg::RK_HEADER;
			q_cmd.len  = len;
		end
	end

	assign q_push = (f_state_q == F_CHECK) && check_cond && !q_full;

	// The last three stored bytes and the frame bytes that are kept at fixed places.
	always_ff @(posedge clk) begin
		if (store_byte) begin
			h0_q <= item.rx_byte;
			h1_q <= h0_q;
			h2_q <= h1_q;
			if (fill_q == CW'(0)) begin
				first_q <= item.rx_byte;
			end
			if (fill_q == CW'(1)) begin
				to_q <= item.rx_byte;
			end
			if (fill_q == CW'(2)) begin
				from_q <= item.rx_byte;
			end
		end
	end

	// Control state, counters and the running CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_state_q  <= F_IDLE;
			fill_q     <= '0;
			lock_end_q <= '0;
			idle_q     <= 16'd0;
			crc_q      <= pdf_pkg::CRC_INIT;
			bit_q      <= 3'd0;
		end else begin
			unique case (f_state_q)
				F_IDLE: begin
					if (accept && is_byte) begin
						if (has_room) begin
							fill_q <= fill_q + CW'(1);
							idle_q <= 16'd0;
							// The byte four places before the new end joins the CRC.
							if (fill_ext >= pdf_pkg::FOLD_START) begin
								crc_q     <= crc_q ^ {h2_q, 8'h00};
								bit_q     <= 3'd0;
								f_state_q <= F_CRC;
							end
						end
					end else if (accept) begin
						idle_q <= idle_inc;
						if (idle_inc >= cfg.timeout_ticks) begin
							fill_q <= '0;
							idle_q <= 16'd0;
							crc_q  <= pdf_pkg::CRC_INIT;
						end
					end
				end
				F_CRC: begin
					crc_q <= crc_step;
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						f_state_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					if (!check_cond) begin
						f_state_q <= F_IDLE;
					end else if (!q_full) begin
						lock_end_q <= fill_q;
						f_state_q  <= F_IDLE;
					end
				end
				default: begin
					f_state_q <= F_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The fill count never passes the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond store depth");

	// A stored byte clears the idle count.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		store_byte |=> (idle_q == 16'd0))
		else $error("idle count not cleared by a stored byte");

	// No byte is written into the region that a pending frame still reads.
	a_write_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(st_wr_en && back_pending) |-> (fill_q >= lock_end_q))
		else $error("store write into a locked region");
`endif

endmodule

/* rtl/pdf_back.sv */
// Back end: turns frame commands into status, header and payload result beats.
module pdf_back #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  pdf_pkg::cmd_t            q_cmd,
	output logic                     q_pop,
	output logic                     st_rd_en,
	output logic [$clog2(DEPTH)-1:0] st_rd_addr,
	input  logic [7:0]               st_rd_data,
	output logic                     result_valid,
	input  logic                     result_stall,
	output pdf_pkg::result_t         result,
	output logic                     pending
);

	localparam int AW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_WAIT
	} b_state_t;

	b_state_t          b_state_q;
	pdf_pkg::result_t  out_q;
	logic              out_valid_q;
	logic [5:0]        idx_q;
	logic [5:0]        len_q;

	logic              out_free;
	logic              pay_load;
	logic [5:0]        idx_next;
	logic              pay_last;
	logic [8:0]        addr_sum;

	// The output register takes a new beat when it is empty or being drained.
	assign out_free     = !out_valid_q || !result_stall;
	assign q_pop        = (b_state_q == B_IDLE) && !q_empty && out_free;
	assign pay_load     = (b_state_q == B_WAIT) && out_free;
	assign idx_next     = idx_q + 6'd1;
	assign pay_last     = idx_next == len_q;
	assign pending      = !q_empty || (b_state_q != B_IDLE);

	// Payload byte i sits at store address six plus i.
	assign addr_sum     = 9'(idx_q) + pdf_pkg::PAYLOAD_OFFSET;
	assign st_rd_en     = b_state_q == B_READ;
	assign st_rd_addr   = addr_sum[AW-1:0];

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Output beat contents and payload position.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.result_kind    <= q_cmd.kind;
			out_q.from_address   <= q_cmd.from_address;
			out_q.to_address     <= q_cmd.to_address;
			out_q.payload_length <= q_cmd.len;
			out_q.data_byte      <= 8'd0;
			out_q.last           <= (q_cmd.kind != pdf_pkg::RK_HEADER) || (q_cmd.len == 6'd0);
			len_q                <= q_cmd.len;
			idx_q                <= 6'd0;
		end else if (pay_load) begin
			out_q.result_kind <= pdf_pkg::RK_PAYLOAD;
			out_q.data_byte   <= st_rd_data;
			out_q.last        <= pay_last;
			idx_q             <= idx_next;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_state_q   <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (q_pop || pay_load) ? 1'b1 : (out_valid_q && result_stall);
			unique case (b_state_q)
				B_IDLE: begin
					if (q_pop && (q_cmd.kind == pdf_pkg::RK_HEADER) && (q_cmd.len != 6'd0)) begin
						b_state_q <= B_READ;
					end
				end
				B_READ: begin
					b_state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (pay_load) begin
						b_state_q <= pay_last ? B_IDLE : B_READ;
					end
				end
				default: begin
					b_state_q <= B_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Reads stay inside the payload of the current frame.
	a_read_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(b_state_q == B_READ) |-> (idx_q < len_q))
		else $error("payload read past the frame length");

	// Payload beats repeat the length of their header.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.result_kind == pdf_pkg::RK_PAYLOAD)) |->
		(out_q.payload_length == len_q))
		else $error("payload beat length differs from header");

	// A status beat is a single final beat with no length.
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ((out_q.result_kind == pdf_pkg::RK_NOT_ADDRESSED) ||
		(out_q.result_kind == pdf_pkg::RK_CRC_ERROR))) |->
		(out_q.last && (out_q.payload_length == 6'd0)))
		else $error("malformed status beat");
`endif

endmodule

/* rtl/packet_deframer_crc16_addr_filter.sv */
// Top level of the packet deframer with CRC-16 check and destination address filter.
// Each input beat is a received byte or a one millisecond tick. When a byte arrives with four
// or more bytes stored and the store not full, the CRC-16 (0x1021, preset 0xFFFF) is folded
// one bit per cycle, followed by the end-of-frame check, which repeats while the frame meets
// its check conditions and the command queue is full; the input stalls meanwhile. Checked
// frames go through a two-entry command queue to the result sequencer, so input and output
// stall on their own. A status or header beat is loaded straight from the queue; each payload
// beat is first read from the frame store, whose read data is registered, and then loaded. After
// a timeout restart, new bytes wait while a queued or active frame still reads payload bytes from
// the part of the store that they would overwrite.
module packet_deframer_crc16_addr_filter #(
	parameter int STORE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pdf_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output pdf_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	pdf_pkg::cfg_t cfg_q;

	logic          st_wr_en;
	logic [AW-1:0] st_wr_addr;
	logic [7:0]    st_wr_data;
	logic          st_rd_en;
	logic [AW-1:0] st_rd_addr;
	logic [7:0]    st_rd_data;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	pdf_pkg::cmd_t push_cmd;
	pdf_pkg::cmd_t pop_cmd;
	logic          back_pending;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address       <= pdf_pkg::RST_OWN_ADDRESS;
			cfg_q.receive_all       <= pdf_pkg::RST_RECEIVE_ALL;
			cfg_q.broadcast_address <= pdf_pkg::RST_BROADCAST_ADDRESS;
			cfg_q.start_byte        <= pdf_pkg::RST_START_BYTE;
			cfg_q.end_byte          <= pdf_pkg::RST_END_BYTE;
			cfg_q.timeout_ticks     <= pdf_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdf_pkg::REG_OWN_ADDRESS:       cfg_q.own_address       <= cfg_data[7:0];
				pdf_pkg::REG_RECEIVE_ALL:       cfg_q.receive_all       <= cfg_data[0];
				pdf_pkg::REG_BROADCAST_ADDRESS: cfg_q.broadcast_address <= cfg_data[7:0];
				pdf_pkg::REG_START_BYTE:        cfg_q.start_byte        <= cfg_data[7:0];
				pdf_pkg::REG_END_BYTE:          cfg_q.end_byte          <= cfg_data[7:0];
				pdf_pkg::REG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: frame state and CRC check.
	pdf_front #(
		.DEPTH(STORE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.st_wr_en     (st_wr_en),
		.st_wr_addr   (st_wr_addr),
		.st_wr_data   (st_wr_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.back_pending (back_pending)
	);

	// Frame store.
	pdf_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	// Command queue between the two halves.
	pdf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end: result beats.
	pdf_back #(
		.DEPTH(STORE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (pop_cmd),
		.q_pop        (q_pop),
		.st_rd_en     (st_rd_en),
		.st_rd_addr   (st_rd_addr),
		.st_rd_data   (st_rd_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.pending      (back_pending)
	);

endmodule
